// ===== src/lcst_pkg.sv =====
`default_nettype none

package lcst_pkg;

  // Tracker geometry
  localparam int TRACK_DEPTH = 16;
  localparam int KEY_BITS    = 64;

  // Port widths fixed by the interface
  localparam int IN_KEY_W    = 64;
  localparam int OUT_SLOT_W  = 4;

  // Derived widths
  localparam int SLOT_W      = $clog2(TRACK_DEPTH);
  localparam int FILL_W      = $clog2(TRACK_DEPTH + 1);

  // One position of the recency chain
  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [SLOT_W-1:0]   slot;
  } entry_t;

  // Lookup result rippling down the chain
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } probe_t;

endpackage

`default_nettype wire

// ===== src/lcst_cell.sv =====
`default_nettype none

module lcst_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire logic [lcst_pkg::KEY_BITS-1:0] probe_key,
  input  wire lcst_pkg::entry_t            prev_i,
  output lcst_pkg::entry_t                 cell_o,
  input  wire lcst_pkg::probe_t            chain_i,
  output lcst_pkg::probe_t                 chain_o
);
  import lcst_pkg::*;

  logic                valid_r;
  logic [KEY_BITS-1:0] key_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                match;
  logic                take;

  // Compare this position against the probe key
  assign match = valid_r && (key_r == probe_key);

  // Pass the first match down the chain
  assign chain_o.hit  = chain_i.hit | match;
  assign chain_o.slot = chain_i.hit ? chain_i.slot : slot_r;

  // Shift from the neighbor unless the hit lies above this position
  assign take = load && !chain_i.hit;

  assign cell_o.valid = valid_r;
  assign cell_o.key   = key_r;
  assign cell_o.slot  = slot_r;

  // Hold valid mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= prev_i.valid;
    end
  end

  // Hold key and slot
  always_ff @(posedge clk) begin
    if (take) begin
      key_r  <= prev_i.key;
      slot_r <= prev_i.slot;
    end
  end

endmodule

`default_nettype wire

// ===== src/lru_connection_slot_tracker.sv =====
`default_nettype none

// LRU connection slot tracker. Each input word carries a peer key; the block
// answers with one output word: whether the key was already tracked, the
// handle slot now holding it, and, when the table was full on a miss, the
// key of the least-recent entry that gave up its slot. The recency order
// lives in a row of cells, one per position, most recent first; every
// lookup compares all cells at once and shifts the row by one position in
// the same cycle, on a hit only down to the hit cell. One word is accepted
// per cycle while in_ready is high, its answer registered; a new word is
// taken while the previous answer is still being taken, as long as the
// output register drains. Reset clears valid marks, fill count, out_valid.
module lru_connection_slot_tracker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lcst_pkg::IN_KEY_W-1:0] in_peer_key,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic [lcst_pkg::OUT_SLOT_W-1:0]    out_slot_index,
  output logic                               out_evicted,
  output logic [lcst_pkg::IN_KEY_W-1:0]      out_evicted_key
);
  import lcst_pkg::*;

  entry_t              ent [TRACK_DEPTH];
  entry_t              prev [TRACK_DEPTH];
  probe_t              chain [TRACK_DEPTH+1];
  entry_t              new_ent;
  logic [KEY_BITS-1:0] key;
  logic                accept;
  logic                full;
  logic                evict;
  logic [SLOT_W-1:0]   slot_nxt;
  logic [FILL_W-1:0]   fill_r;

  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [OUT_SLOT_W-1:0]   out_slot_index_r;
  logic                    out_evicted_r;
  logic [IN_KEY_W-1:0]     out_evicted_key_r;

  assign key      = in_peer_key[KEY_BITS-1:0];
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Table is full once the tail position holds a valid entry
  assign full  = ent[TRACK_DEPTH-1].valid;
  assign evict = !chain[TRACK_DEPTH].hit && full;

  // Pick the slot for the head entry
  always_comb begin
    if (chain[TRACK_DEPTH].hit) begin
      slot_nxt = chain[TRACK_DEPTH].slot;
    end else if (full) begin
      slot_nxt = ent[TRACK_DEPTH-1].slot;
    end else begin
      slot_nxt = fill_r[SLOT_W-1:0];
    end
  end

  assign new_ent.valid = 1'b1;
  assign new_ent.key   = key;
  assign new_ent.slot  = slot_nxt;

  assign chain[0] = '0;

  // Row of recency cells, head first
  for (genvar i = 0; i < TRACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev[i] = new_ent;
    end else begin : g_body
      assign prev[i] = ent[i-1];
    end
    lcst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (accept),
      .probe_key (key),
      .prev_i    (prev[i]),
      .cell_o    (ent[i]),
      .chain_i   (chain[i]),
      .chain_o   (chain[i+1])
    );
  end

  // Advance fill count on a miss with free room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept && !chain[TRACK_DEPTH].hit && !full) begin
      fill_r <= fill_r + FILL_W'(1);
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r         <= chain[TRACK_DEPTH].hit;
      out_slot_index_r  <= OUT_SLOT_W'(slot_nxt);
      out_evicted_r     <= evict;
      out_evicted_key_r <= evict ? IN_KEY_W'(ent[TRACK_DEPTH-1].key) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot_index  = out_slot_index_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule

`default_nettype wire
